// File: rtl/fsktd_pkg.sv
package fsktd_pkg;

  localparam int SYMBOL_SAMPLES    = 160;
  localparam int CARRIER_ON_LEVEL  = 60;
  localparam int CARRIER_OFF_LEVEL = 50;
  localparam int HOLD_SAMPLES      = 50;

  localparam int LINE_LEN = SYMBOL_SAMPLES + 1;
  localparam int PTR_W    = $clog2(LINE_LEN);
  localparam int HOLD_W   = 6;
  localparam int COEF_W   = 18;
  localparam int PADDR_W  = 5;

  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(LINE_LEN - 1);
  localparam logic [HOLD_W-1:0] HOLD_LOAD = HOLD_W'(HOLD_SAMPLES);

  // carrier levels in Q16.16
  localparam logic [47:0] CARRIER_ON_TH  = 48'(CARRIER_ON_LEVEL) * 48'd65536;
  localparam logic [47:0] CARRIER_OFF_TH = 48'(CARRIER_OFF_LEVEL) * 48'd65536;

  // low-pass, Q2.30
  localparam logic signed [31:0] LP_B0 = 32'sd402728;
  localparam logic signed [31:0] LP_B1 = 32'sd805457;
  localparam logic signed [31:0] LP_B2 = 32'sd402728;
  localparam logic signed [31:0] LP_A1 = 32'sd2087866989;
  localparam logic signed [31:0] LP_A2 = 32'sd1015736079;

  typedef enum logic [2:0] {
    REG_SPACE_COS_STEP   = 3'd0,
    REG_SPACE_SIN_STEP   = 3'd1,
    REG_SPACE_COS_WINDOW = 3'd2,
    REG_SPACE_SIN_WINDOW = 3'd3,
    REG_MARK_COS_STEP    = 3'd4,
    REG_MARK_SIN_STEP    = 3'd5,
    REG_MARK_COS_WINDOW  = 3'd6,
    REG_MARK_SIN_WINDOW  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] space_cos_step;
    logic signed [COEF_W-1:0] space_sin_step;
    logic signed [COEF_W-1:0] space_cos_window;
    logic signed [COEF_W-1:0] space_sin_window;
    logic signed [COEF_W-1:0] mark_cos_step;
    logic signed [COEF_W-1:0] mark_sin_step;
    logic signed [COEF_W-1:0] mark_cos_window;
    logic signed [COEF_W-1:0] mark_sin_window;
  } coef_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SP1,
    ST_SP2,
    ST_SP3,
    ST_MK1,
    ST_MK2,
    ST_MK3,
    ST_ENS,
    ST_WBM,
    ST_ENM,
    ST_EWAIT,
    ST_WBD,
    ST_LP1,
    ST_LP2,
    ST_LP3,
    ST_LWAIT,
    ST_WBL,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_RES1,
    MUL_RES2,
    MUL_RES3,
    MUL_EN,
    MUL_LP1,
    MUL_LP2,
    MUL_LP3
  } mul_op_t;

  typedef enum logic {
    TONE_SPACE,
    TONE_MARK
  } tone_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_ADD,
    ACC_LOAD_SUB,
    ACC_ADD,
    ACC_SUB
  } acc_mode_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_SPACE,
    WB_MARK,
    WB_DEC,
    WB_LP
  } wb_t;

  typedef struct packed {
    acc_mode_t mode_a;
    acc_mode_t mode_b;
    logic      base_x;
    logic      shift14;
  } acc_ctl_t;

  typedef struct packed {
    logic      load;
    mul_op_t   op;
    tone_t     tone;
    acc_ctl_t  acc;
    wb_t       wb;
    logic      finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  function automatic logic signed [31:0] ext_coef(input logic signed [COEF_W-1:0] v);
    return 32'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -65'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/fsktd_regs.sv
module fsktd_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fsktd_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output fsktd_pkg::coef_t               coef_o
);

  fsktd_pkg::coef_t     coef_r;
  fsktd_pkg::reg_idx_t  idx;
  logic                 wr_en;
  logic signed [fsktd_pkg::COEF_W-1:0] wval;
  logic signed [fsktd_pkg::COEF_W-1:0] rval;

  assign pready = 1'b1;
  assign idx    = fsktd_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign wval   = pwdata[fsktd_pkg::COEF_W-1:0];
  assign coef_o = coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (wr_en) begin
      case (idx)
        fsktd_pkg::REG_SPACE_COS_STEP:   coef_r.space_cos_step   <= wval;
        fsktd_pkg::REG_SPACE_SIN_STEP:   coef_r.space_sin_step   <= wval;
        fsktd_pkg::REG_SPACE_COS_WINDOW: coef_r.space_cos_window <= wval;
        fsktd_pkg::REG_SPACE_SIN_WINDOW: coef_r.space_sin_window <= wval;
        fsktd_pkg::REG_MARK_COS_STEP:    coef_r.mark_cos_step    <= wval;
        fsktd_pkg::REG_MARK_SIN_STEP:    coef_r.mark_sin_step    <= wval;
        fsktd_pkg::REG_MARK_COS_WINDOW:  coef_r.mark_cos_window  <= wval;
        fsktd_pkg::REG_MARK_SIN_WINDOW:  coef_r.mark_sin_window  <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fsktd_pkg::REG_SPACE_COS_STEP:   rval = coef_r.space_cos_step;
      fsktd_pkg::REG_SPACE_SIN_STEP:   rval = coef_r.space_sin_step;
      fsktd_pkg::REG_SPACE_COS_WINDOW: rval = coef_r.space_cos_window;
      fsktd_pkg::REG_SPACE_SIN_WINDOW: rval = coef_r.space_sin_window;
      fsktd_pkg::REG_MARK_COS_STEP:    rval = coef_r.mark_cos_step;
      fsktd_pkg::REG_MARK_SIN_STEP:    rval = coef_r.mark_sin_step;
      fsktd_pkg::REG_MARK_COS_WINDOW:  rval = coef_r.mark_cos_window;
      fsktd_pkg::REG_MARK_SIN_WINDOW:  rval = coef_r.mark_sin_window;
      default:                         rval = '0;
    endcase
  end

  assign prdata = fsktd_pkg::ext_coef(rval);

endmodule

// File: rtl/fsktd_ctrl.sv
module fsktd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fsktd_pkg::dp_status_t status_i,
  output fsktd_pkg::dp_cmd_t    cmd_o
);

  fsktd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsktd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    case (state_r)
      fsktd_pkg::ST_IDLE:  state_nxt = in_valid ? fsktd_pkg::ST_SP1 : fsktd_pkg::ST_IDLE;
      fsktd_pkg::ST_SP1:   state_nxt = fsktd_pkg::ST_SP2;
      fsktd_pkg::ST_SP2:   state_nxt = fsktd_pkg::ST_SP3;
      fsktd_pkg::ST_SP3:   state_nxt = fsktd_pkg::ST_MK1;
      fsktd_pkg::ST_MK1:   state_nxt = fsktd_pkg::ST_MK2;
      fsktd_pkg::ST_MK2:   state_nxt = fsktd_pkg::ST_MK3;
      fsktd_pkg::ST_MK3:   state_nxt = fsktd_pkg::ST_ENS;
      fsktd_pkg::ST_ENS:   state_nxt = fsktd_pkg::ST_WBM;
      fsktd_pkg::ST_WBM:   state_nxt = fsktd_pkg::ST_ENM;
      fsktd_pkg::ST_ENM:   state_nxt = fsktd_pkg::ST_EWAIT;
      fsktd_pkg::ST_EWAIT: state_nxt = fsktd_pkg::ST_WBD;
      fsktd_pkg::ST_WBD:   state_nxt = fsktd_pkg::ST_LP1;
      fsktd_pkg::ST_LP1:   state_nxt = fsktd_pkg::ST_LP2;
      fsktd_pkg::ST_LP2:   state_nxt = fsktd_pkg::ST_LP3;
      fsktd_pkg::ST_LP3:   state_nxt = fsktd_pkg::ST_LWAIT;
      fsktd_pkg::ST_LWAIT: state_nxt = fsktd_pkg::ST_WBL;
      fsktd_pkg::ST_WBL:   state_nxt = fsktd_pkg::ST_FIN;
      fsktd_pkg::ST_FIN: begin
        state_nxt = status_i.out_busy ? fsktd_pkg::ST_FIN : fsktd_pkg::ST_IDLE;
      end
      default:             state_nxt = fsktd_pkg::ST_IDLE;
    endcase
  end

  // products and accumulate controls are registered before accumulation
  always_comb begin
    in_ready           = 1'b0;
    cmd_o              = '0;
    cmd_o.op           = fsktd_pkg::MUL_NONE;
    cmd_o.tone         = fsktd_pkg::TONE_SPACE;
    cmd_o.acc.mode_a   = fsktd_pkg::ACC_HOLD;
    cmd_o.acc.mode_b   = fsktd_pkg::ACC_HOLD;
    cmd_o.wb           = fsktd_pkg::WB_NONE;
    case (state_r)
      fsktd_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd_o.load = in_valid;
      end
      fsktd_pkg::ST_SP1, fsktd_pkg::ST_MK1: begin
        cmd_o.op           = fsktd_pkg::MUL_RES1;
        cmd_o.tone         = (state_r == fsktd_pkg::ST_MK1) ? fsktd_pkg::TONE_MARK
                                                            : fsktd_pkg::TONE_SPACE;
        cmd_o.acc.mode_a   = fsktd_pkg::ACC_LOAD_SUB;
        cmd_o.acc.mode_b   = fsktd_pkg::ACC_LOAD_SUB;
        cmd_o.acc.base_x   = 1'b1;
      end
      fsktd_pkg::ST_SP2, fsktd_pkg::ST_MK2: begin
        cmd_o.op           = fsktd_pkg::MUL_RES2;
        cmd_o.tone         = (state_r == fsktd_pkg::ST_MK2) ? fsktd_pkg::TONE_MARK
                                                            : fsktd_pkg::TONE_SPACE;
        cmd_o.acc.mode_a   = fsktd_pkg::ACC_ADD;
        cmd_o.acc.mode_b   = fsktd_pkg::ACC_ADD;
        cmd_o.wb           = (state_r == fsktd_pkg::ST_MK2) ? fsktd_pkg::WB_SPACE
                                                            : fsktd_pkg::WB_NONE;
      end
      fsktd_pkg::ST_SP3, fsktd_pkg::ST_MK3: begin
        cmd_o.op           = fsktd_pkg::MUL_RES3;
        cmd_o.tone         = (state_r == fsktd_pkg::ST_MK3) ? fsktd_pkg::TONE_MARK
                                                            : fsktd_pkg::TONE_SPACE;
        cmd_o.acc.mode_a   = fsktd_pkg::ACC_SUB;
        cmd_o.acc.mode_b   = fsktd_pkg::ACC_ADD;
      end
      fsktd_pkg::ST_ENS: begin
        cmd_o.op           = fsktd_pkg::MUL_EN;
        cmd_o.tone         = fsktd_pkg::TONE_SPACE;
        cmd_o.acc.mode_a   = fsktd_pkg::ACC_LOAD_SUB;
        cmd_o.acc.mode_b   = fsktd_pkg::ACC_LOAD_SUB;
        cmd_o.acc.shift14  = 1'b1;
      end
      fsktd_pkg::ST_WBM: begin
        cmd_o.wb           = fsktd_pkg::WB_MARK;
      end
      fsktd_pkg::ST_ENM: begin
        cmd_o.op           = fsktd_pkg::MUL_EN;
        cmd_o.tone         = fsktd_pkg::TONE_MARK;
        cmd_o.acc.mode_a   = fsktd_pkg::ACC_ADD;
        cmd_o.acc.mode_b   = fsktd_pkg::ACC_ADD;
        cmd_o.acc.shift14  = 1'b1;
      end
      fsktd_pkg::ST_EWAIT: ;
      fsktd_pkg::ST_WBD: begin
        cmd_o.wb           = fsktd_pkg::WB_DEC;
      end
      fsktd_pkg::ST_LP1: begin
        cmd_o.op           = fsktd_pkg::MUL_LP1;
        cmd_o.acc.mode_a   = fsktd_pkg::ACC_LOAD_ADD;
        cmd_o.acc.mode_b   = fsktd_pkg::ACC_LOAD_ADD;
      end
      fsktd_pkg::ST_LP2: begin
        cmd_o.op           = fsktd_pkg::MUL_LP2;
        cmd_o.acc.mode_a   = fsktd_pkg::ACC_ADD;
        cmd_o.acc.mode_b   = fsktd_pkg::ACC_SUB;
      end
      fsktd_pkg::ST_LP3: begin
        cmd_o.op           = fsktd_pkg::MUL_LP3;
        cmd_o.acc.mode_a   = fsktd_pkg::ACC_ADD;
        cmd_o.acc.mode_b   = fsktd_pkg::ACC_HOLD;
      end
      fsktd_pkg::ST_LWAIT: ;
      fsktd_pkg::ST_WBL: begin
        cmd_o.wb           = fsktd_pkg::WB_LP;
      end
      fsktd_pkg::ST_FIN: begin
        cmd_o.finish       = !status_i.out_busy;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/fsktd_dp.sv
module fsktd_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fsktd_pkg::coef_t      coef_i,
  input  fsktd_pkg::dp_cmd_t    cmd_i,
  input  logic signed [15:0]    in_sample,
  input  logic                  in_block_end,
  input  logic                  out_ready,
  output fsktd_pkg::dp_status_t status_o,
  output logic                  out_valid,
  output logic                  out_bit_out,
  output logic                  out_carrier_present,
  output logic                  out_block_end_out
);

  // delay line
  logic signed [15:0]          mem [fsktd_pkg::LINE_LEN];
  logic signed [15:0]          mem_q_r;
  logic [fsktd_pkg::PTR_W-1:0] wr_ptr_r;
  logic [fsktd_pkg::PTR_W-1:0] rd_ptr;
  logic                        full_r;
  logic                        xo_ok_r;
  logic signed [15:0]          x_r;
  logic                        blk_r;
  logic signed [15:0]          x_old;

  // resonator and filter state
  logic signed [31:0] sre_r, sim_r, mre_r, mim_r;
  logic signed [31:0] d1_r, d2_r, y1_r, y2_r, dec_r;
  logic [fsktd_pkg::HOLD_W-1:0] hold_r, hold_nxt;

  // multiply-accumulate lanes
  logic signed [31:0] op_a0, op_b0, op_a1, op_b1;
  logic signed [31:0] c_sel, s_sel, cw_sel, sw_sel, vr_sel, vi_sel;
  logic signed [63:0] p0_r, p1_r, acc0_r, acc1_r, acc0_nxt, acc1_nxt;
  logic signed [63:0] term0, term1, base0;
  fsktd_pkg::acc_ctl_t acc_d_r;

  logic signed [64:0] sum0, sum1, rnd0, rnd1, sum_all, rnd_lp;
  logic signed [31:0] res_re, res_im, dec_val, lp_val;

  logic signed [32:0] y_ext, y_mag;
  logic               out_valid_r, out_bit_r, out_carrier_r, out_blk_r;

  assign rd_ptr = (wr_ptr_r == fsktd_pkg::PTR_LAST) ? '0
                                                    : wr_ptr_r + fsktd_pkg::PTR_W'(1);

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      mem[wr_ptr_r] <= in_sample;
      mem_q_r       <= mem[rd_ptr];
      x_r           <= in_sample;
      blk_r         <= in_block_end;
    end
  end

  // the slot read back holds a real sample only once the line has wrapped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      full_r   <= 1'b0;
      xo_ok_r  <= 1'b0;
    end else if (cmd_i.load) begin
      wr_ptr_r <= rd_ptr;
      full_r   <= full_r | (wr_ptr_r == fsktd_pkg::PTR_LAST);
      xo_ok_r  <= full_r | (wr_ptr_r == fsktd_pkg::PTR_LAST);
    end
  end

  assign x_old = xo_ok_r ? mem_q_r : '0;

  always_comb begin
    if (cmd_i.tone == fsktd_pkg::TONE_MARK) begin
      c_sel  = fsktd_pkg::ext_coef(coef_i.mark_cos_step);
      s_sel  = fsktd_pkg::ext_coef(coef_i.mark_sin_step);
      cw_sel = fsktd_pkg::ext_coef(coef_i.mark_cos_window);
      sw_sel = fsktd_pkg::ext_coef(coef_i.mark_sin_window);
      vr_sel = mre_r;
      vi_sel = mim_r;
    end else begin
      c_sel  = fsktd_pkg::ext_coef(coef_i.space_cos_step);
      s_sel  = fsktd_pkg::ext_coef(coef_i.space_sin_step);
      cw_sel = fsktd_pkg::ext_coef(coef_i.space_cos_window);
      sw_sel = fsktd_pkg::ext_coef(coef_i.space_sin_window);
      vr_sel = sre_r;
      vi_sel = sim_r;
    end
  end

  always_comb begin
    case (cmd_i.op)
      fsktd_pkg::MUL_RES1: begin
        op_a0 = cw_sel;  op_b0 = 32'(x_old);
        op_a1 = sw_sel;  op_b1 = 32'(x_old);
      end
      fsktd_pkg::MUL_RES2: begin
        op_a0 = c_sel;   op_b0 = vr_sel;
        op_a1 = c_sel;   op_b1 = vi_sel;
      end
      fsktd_pkg::MUL_RES3: begin
        op_a0 = s_sel;   op_b0 = vi_sel;
        op_a1 = s_sel;   op_b1 = vr_sel;
      end
      fsktd_pkg::MUL_EN: begin
        op_a0 = vr_sel;  op_b0 = vr_sel;
        op_a1 = vi_sel;  op_b1 = vi_sel;
      end
      fsktd_pkg::MUL_LP1: begin
        op_a0 = fsktd_pkg::LP_B0;  op_b0 = dec_r;
        op_a1 = fsktd_pkg::LP_A1;  op_b1 = y1_r;
      end
      fsktd_pkg::MUL_LP2: begin
        op_a0 = fsktd_pkg::LP_B1;  op_b0 = d1_r;
        op_a1 = fsktd_pkg::LP_A2;  op_b1 = y2_r;
      end
      fsktd_pkg::MUL_LP3: begin
        op_a0 = fsktd_pkg::LP_B2;  op_b0 = d2_r;
        op_a1 = '0;                op_b1 = '0;
      end
      default: begin
        op_a0 = '0;  op_b0 = '0;
        op_a1 = '0;  op_b1 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p0_r <= 64'(op_a0) * 64'(op_b0);
    p1_r <= 64'(op_a1) * 64'(op_b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_d_r <= '0;
    end else begin
      acc_d_r <= cmd_i.acc;
    end
  end

  assign term0 = acc_d_r.shift14 ? (p0_r >>> 14) : p0_r;
  assign term1 = acc_d_r.shift14 ? (p1_r >>> 14) : p1_r;
  assign base0 = acc_d_r.base_x ? {{32{x_r[15]}}, x_r, 16'b0} : '0;

  always_comb begin
    case (acc_d_r.mode_a)
      fsktd_pkg::ACC_LOAD_ADD: acc0_nxt = base0 + term0;
      fsktd_pkg::ACC_LOAD_SUB: acc0_nxt = base0 - term0;
      fsktd_pkg::ACC_ADD:      acc0_nxt = acc0_r + term0;
      fsktd_pkg::ACC_SUB:      acc0_nxt = acc0_r - term0;
      default:                 acc0_nxt = acc0_r;
    endcase
    case (acc_d_r.mode_b)
      fsktd_pkg::ACC_LOAD_ADD: acc1_nxt = term1;
      fsktd_pkg::ACC_LOAD_SUB: acc1_nxt = -term1;
      fsktd_pkg::ACC_ADD:      acc1_nxt = acc1_r + term1;
      fsktd_pkg::ACC_SUB:      acc1_nxt = acc1_r - term1;
      default:                 acc1_nxt = acc1_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc0_r <= acc0_nxt;
    acc1_r <= acc1_nxt;
  end

  assign sum0    = {acc0_r[63], acc0_r};
  assign sum1    = {acc1_r[63], acc1_r};
  assign rnd0    = sum0 + 65'sd32768;
  assign rnd1    = sum1 + 65'sd32768;
  assign sum_all = sum0 + sum1;
  assign rnd_lp  = sum_all + 65'sd536870912;
  assign res_re  = fsktd_pkg::sat32(rnd0 >>> 16);
  assign res_im  = fsktd_pkg::sat32(rnd1 >>> 16);
  assign dec_val = fsktd_pkg::sat32(sum_all);
  assign lp_val  = fsktd_pkg::sat32(rnd_lp >>> 30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sre_r <= '0;
      sim_r <= '0;
      mre_r <= '0;
      mim_r <= '0;
      d1_r  <= '0;
      d2_r  <= '0;
      y1_r  <= '0;
      y2_r  <= '0;
    end else begin
      case (cmd_i.wb)
        fsktd_pkg::WB_SPACE: begin
          sre_r <= res_re;
          sim_r <= res_im;
        end
        fsktd_pkg::WB_MARK: begin
          mre_r <= res_re;
          mim_r <= res_im;
        end
        fsktd_pkg::WB_LP: begin
          y1_r <= lp_val;
          y2_r <= y1_r;
          d1_r <= dec_r;
          d2_r <= d1_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.wb == fsktd_pkg::WB_DEC) begin
      dec_r <= dec_val;
    end
  end

  // carrier hold with hysteresis on |y|
  assign y_ext = {y1_r[31], y1_r};
  assign y_mag = y_ext[32] ? -y_ext : y_ext;

  always_comb begin
    hold_nxt = hold_r;
    if ({15'b0, y_mag} > fsktd_pkg::CARRIER_ON_TH) begin
      hold_nxt = fsktd_pkg::HOLD_LOAD;
    end else if (hold_r != '0 && {15'b0, y_mag} < fsktd_pkg::CARRIER_OFF_TH) begin
      hold_nxt = hold_r - fsktd_pkg::HOLD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        hold_r      <= hold_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.finish) begin
      out_bit_r     <= (hold_nxt != '0) ? ~y1_r[31] : 1'b1;
      out_carrier_r <= (hold_nxt != '0);
      out_blk_r     <= blk_r;
    end
  end

  assign status_o.out_busy   = out_valid_r & ~out_ready;
  assign out_valid           = out_valid_r;
  assign out_bit_out         = out_bit_r;
  assign out_carrier_present = out_carrier_r;
  assign out_block_end_out   = out_blk_r;

`ifndef ASSERT_OFF
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_r <= fsktd_pkg::PTR_LAST)
    else $error("delay pointer out of range");

  a_hold_max: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r <= fsktd_pkg::HOLD_LOAD)
    else $error("hold counter above load value");

  a_idle_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_carrier_r |-> out_bit_r)
    else $error("bit not forced to mark without carrier");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.finish |=> out_valid_r)
    else $error("finished beat not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.finish |-> !(out_valid_r && !out_ready))
    else $error("result overwritten while stalled");
`endif

endmodule

// File: rtl/fsk_tone_demodulator.sv
// FSK tone demodulator, one Q1.15 audio sample in, one line bit out.
// Input channel (in_valid/in_ready): in_sample and in_block_end per beat.
// Result channel (out_valid/out_ready): out_bit_out, out_carrier_present
// and out_block_end_out, exactly one beat per accepted input beat, in order.
// Configuration: APB-style port, eight 18-bit Q2.16 resonator coefficients
// at byte addresses 0x00..0x1C; write only while no sample is in flight.
// Results are registered after the resonator, energy and low-pass steps.
// The two shared 32x32 multiply-accumulate lanes run the resonators,
// energy and low-pass in eleven issue slots, beside the delay-line read
// and the carrier update; a sample is taken once the last one is finished.
// in_ready is high only while the controller is idle; a new sample can be
// taken while the previous result waits in the output register.
// If out_ready stays low, the next result waits in the controller until the
// output register drains, and no further sample is accepted meanwhile.
// Reset (rst_n low, synchronous) clears coefficients, resonators, filter
// history, carrier hold and the delay line (via a fill flag), and drops
// out_valid.
module fsk_tone_demodulator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            in_sample,
  input  logic                          in_block_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_bit_out,
  output logic                          out_carrier_present,
  output logic                          out_block_end_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fsktd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  fsktd_pkg::coef_t      coef;
  fsktd_pkg::dp_cmd_t    cmd;
  fsktd_pkg::dp_status_t status;

  fsktd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef)
  );

  fsktd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status_i (status),
    .cmd_o    (cmd)
  );

  fsktd_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .coef_i              (coef),
    .cmd_i               (cmd),
    .in_sample           (in_sample),
    .in_block_end        (in_block_end),
    .out_ready           (out_ready),
    .status_o            (status),
    .out_valid           (out_valid),
    .out_bit_out         (out_bit_out),
    .out_carrier_present (out_carrier_present),
    .out_block_end_out   (out_block_end_out)
  );

endmodule
